// File: hw/rtl/rmss_pkg.sv
// ----------------------------------------------------------------------------
// rmss_pkg
// Shared types and constants of the running mean, stddev and skewness block.
// ----------------------------------------------------------------------------
package rmss_pkg;

	localparam int CHANNELS_DEF   = 8;
	localparam int COUNT_BITS_DEF = 16;

	// configuration register indexes
	localparam logic [1:0] REG_ENABLE_MEAN     = 2'd0;
	localparam logic [1:0] REG_ENABLE_STDDEV   = 2'd1;
	localparam logic [1:0] REG_ENABLE_SKEWNESS = 2'd2;
	localparam logic [1:0] REG_CLEAR_PER_TICK  = 2'd3;

	// statistic kinds
	localparam logic [1:0] KIND_MEAN     = 2'd0;
	localparam logic [1:0] KIND_STDDEV   = 2'd1;
	localparam logic [1:0] KIND_SKEWNESS = 2'd2;

	typedef struct packed {
		logic [2:0]         channel;
		logic signed [15:0] sample;
		logic               restart;
		logic               report;
	} sample_item_t;

	typedef struct packed {
		logic [2:0]         out_channel;
		logic [1:0]         kind;
		logic signed [31:0] value;
		logic               last;
		logic               overflow;
	} stat_item_t;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic valid;
		logic clr;
		logic sub;
		logic hi;
	} mac_ctrl_t;

	typedef enum logic {
		DU_DIV,
		DU_SQRT
	} du_op_t;

	typedef struct packed {
		logic   start;
		du_op_t op;
	} du_req_t;

endpackage

// File: hw/rtl/rmss_mac.sv
// ----------------------------------------------------------------------------
// rmss_mac
// Shared 32x32 multiplier with a 128-bit add/subtract accumulator.
// ----------------------------------------------------------------------------
module rmss_mac import rmss_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  mac_ctrl_t    ctrl,
	input  logic [31:0]  a,
	input  logic [31:0]  b,
	output logic [127:0] acc
);

	mac_ctrl_t    ctrl_s1;
	logic [63:0]  prod_s1;
	logic [127:0] acc_q;
	logic [127:0] base;
	logic [127:0] term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		if (ctrl_s1.valid) begin
			acc_q <= ctrl_s1.sub ? base - term : base + term;
		end
	end

	always_comb begin
		base = ctrl_s1.clr ? 128'd0 : acc_q;
		term = ctrl_s1.hi ? {32'd0, prod_s1, 32'd0} : {64'd0, prod_s1};
	end

	assign acc = acc_q;

endmodule

// File: hw/rtl/rmss_du.sv
// ----------------------------------------------------------------------------
// rmss_du
// Iterative unit: 128-bit restoring divide or 64-bit floor square root,
// one bit or one root digit per cycle.
// ----------------------------------------------------------------------------
module rmss_du import rmss_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  du_req_t      req,
	input  logic [127:0] num,
	input  logic [127:0] den,
	output logic         busy,
	output logic [127:0] result
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t       state_q;
	du_op_t       op_q;
	logic [6:0]   cnt_q;
	logic [127:0] num_q;
	logic [127:0] den_q;
	logic [128:0] rem_q;
	logic [127:0] quo_q;

	logic [128:0] rem_sh;
	logic         ge;
	logic [128:0] rem_d;
	logic [63:0]  rb;
	logic         sge;

	always_comb begin
		rem_sh = {rem_q[127:0], num_q[127]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_d  = ge ? rem_sh - {1'b0, den_q} : rem_sh;
		rb     = quo_q[63:0] + den_q[63:0];
		sge    = rem_q[63:0] >= rb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						op_q    <= req.op;
						quo_q   <= '0;
						state_q <= ST_RUN;
						if (req.op == DU_DIV) begin
							num_q <= num;
							den_q <= den;
							rem_q <= '0;
							cnt_q <= 7'd127;
						end else begin
							rem_q <= {65'd0, num[63:0]};
							den_q <= {64'd0, 64'h4000_0000_0000_0000};
							cnt_q <= 7'd31;
						end
					end
				end
				ST_RUN: begin
					if (op_q == DU_DIV) begin
						rem_q <= rem_d;
						num_q <= {num_q[126:0], 1'b0};
						quo_q <= {quo_q[126:0], ge};
					end else begin
						// one root digit per step
						if (sge) begin
							rem_q[63:0] <= rem_q[63:0] - rb;
							quo_q[63:0] <= {1'b0, quo_q[63:1]} + den_q[63:0];
						end else begin
							quo_q[63:0] <= {1'b0, quo_q[63:1]};
						end
						den_q[63:0] <= {2'b00, den_q[63:2]};
					end
					if (cnt_q == 7'd0) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q - 7'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = (state_q == ST_RUN);
	assign result = quo_q;

endmodule

// File: hw/rtl/running_mean_stddev_skewness_top.sv
// ----------------------------------------------------------------------------
// running_mean_stddev_skewness_top
// Per-channel running sums of x, x^2, x^3 with mean, stddev and skewness
// reports.
// ----------------------------------------------------------------------------
// One item is taken at a time. An item without report makes two passes
// through the shared 32x32 multiplier for x^2 and x^3 and then updates the
// channel memory. For an item with report, 14 more multiplier passes build
// n*S2, S1^2, the third-moment numerator and the denominator, and the
// iterative divide/square-root unit runs one 32-step square root and three
// 128-step divisions (skewness, mean, stddev). The enabled statistics then
// leave one per cycle while the receiver takes them, through an output
// register that the next item does not wait for.
module running_mean_stddev_skewness_top import rmss_pkg::*; #(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [0:0]   cfg_data,
	input  logic         sample_valid,
	output logic         sample_ready,
	input  sample_item_t sample_item,
	output logic         stat_valid,
	input  logic         stat_ready,
	output stat_item_t   stat_item
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int EW = 144 + COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] LIMIT = {COUNT_BITS{1'b1}};

	typedef enum logic [5:0] {
		S_IDLE, S_SQ, S_SQW, S_CU, S_CUW, S_UPD,
		S_A0, S_A1, S_AW, S_B0, S_BW, S_D, S_DW,
		S_K0, S_K1, S_KW,
		S_N0, S_N1, S_N2, S_N3, S_N4, S_N5, S_NW, S_E0,
		S_RT, S_R0, S_R1, S_RW,
		S_SKG, S_SKW, S_MG, S_MW, S_SG, S_SW, S_EMIT
	} state_t;

	state_t state_q;

	logic en_mean_q, en_std_q, en_skew_q, clr_tick_q;

	sample_item_t item_q;
	logic [AW-1:0] addr_q;
	logic [CHANNELS-1:0] valid_q;
	logic [CHANNELS-1:0] tick_q;
	logic [EW-1:0] mem_q [CHANNELS];
	logic [EW-1:0] rd_q;

	logic [30:0]             smag2_q;
	logic signed [31:0]      s1_q;
	logic [47:0]             s2_q;
	logic signed [63:0]      s3_q;
	logic [COUNT_BITS-1:0]   n_q;
	logic [63:0]             a_q;
	logic [63:0]             sq_q;
	logic [63:0]             d_q;
	logic [31:0]             nn_q;
	logic [63:0]             k_q;
	logic [127:0]            num_q;
	logic                    skneg_q;
	logic [31:0]             r_q;
	logic [31:0]             skew_q;
	logic [31:0]             mean_q;
	logic [31:0]             std_q;
	logic [2:0]              pend_q;
	logic                    stat_valid_q;
	stat_item_t              stat_q;

	// datapath helpers
	logic [AW+2:0]          ch_ext;
	logic [15:0]            smag;
	logic                   clr_ch;
	logic                   use_old;
	logic signed [31:0]     b1;
	logic [47:0]            b2;
	logic signed [63:0]     b3;
	logic [COUNT_BITS-1:0]  bn;
	logic signed [31:0]     s1n;
	logic [47:0]            s2n;
	logic signed [63:0]     s3n;
	logic [COUNT_BITS-1:0]  nn_new;
	logic [63:0]            cube;
	logic [EW-1:0]          mem_wd;
	logic                   mem_we;
	logic [31:0]            m1;
	logic                   neg1;
	logic [63:0]            s3m;
	logic [63:0]            j64;
	logic [31:0]            n32;
	logic [31:0]            n3;
	logic [127:0]           acc;
	logic [127:0]           nmag;
	logic [63:0]            sq_acc;
	logic [127:0]           quo;
	logic                   du_busy;
	mac_ctrl_t              mctl;
	logic [31:0]            ma;
	logic [31:0]            mb;
	du_req_t                dreq;
	logic [127:0]           dnum;
	logic [127:0]           dden;
	logic [2:0]             pick;
	logic [2:0]             rest;
	logic [1:0]             pick_kind;
	logic [31:0]            pick_val;
	logic                   load;
	logic [31:0]            skew_sat;

	rmss_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mctl),
		.a      (ma),
		.b      (mb),
		.acc    (acc)
	);

	rmss_du u_du (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.num    (dnum),
		.den    (dden),
		.busy   (du_busy),
		.result (quo)
	);

	always_comb begin
		ch_ext  = (AW + 3)'(sample_item.channel);
		smag    = item_q.sample[15] ? 16'(-item_q.sample) : 16'(item_q.sample);
		clr_ch  = item_q.restart | (clr_tick_q & tick_q[addr_q]);
		use_old = valid_q[addr_q] & ~clr_ch;
		b1      = use_old ? signed'(rd_q[31:0]) : 32'sd0;
		b2      = use_old ? rd_q[79:32] : 48'd0;
		b3      = use_old ? signed'(rd_q[143:80]) : 64'sd0;
		bn      = use_old ? rd_q[EW-1:144] : '0;
		cube    = {18'd0, acc[45:0]};
		if (bn != LIMIT) begin
			s1n    = b1 + {{16{item_q.sample[15]}}, item_q.sample};
			s2n    = b2 + {17'd0, smag2_q};
			s3n    = item_q.sample[15] ? b3 - signed'(cube) : b3 + signed'(cube);
			nn_new = bn + 1'b1;
		end else begin
			s1n    = b1;
			s2n    = b2;
			s3n    = b3;
			nn_new = bn;
		end
		mem_wd = {nn_new, s3n, s2n, s1n};
		mem_we = (state_q == S_UPD);

		neg1   = s1_q[31];
		m1     = neg1 ? 32'(-s1_q) : 32'(s1_q);
		s3m    = s3_q[63] ? 64'(-s3_q) : 64'(s3_q);
		j64    = {sq_q[62:0], 1'b0};
		n32    = 32'(n_q);
		n3     = {n32[30:0], 1'b0} + n32;
		nmag   = acc[127] ? 128'd0 - acc : acc;
		sq_acc = acc[63:0];

		if (quo[127:32] != '0) begin
			skew_sat = skneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if (skneg_q) begin
			skew_sat = (quo[31:0] > 32'h8000_0000) ? 32'h8000_0000 : 32'd0 - quo[31:0];
		end else begin
			skew_sat = quo[31] ? 32'h7FFF_FFFF : quo[31:0];
		end
	end

	// multiplier schedule
	always_comb begin
		mctl = '0;
		ma   = '0;
		mb   = '0;
		case (state_q)
			S_SQ: begin
				mctl = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, hi: 1'b0};
				ma   = 32'(smag);
				mb   = 32'(smag);
			end
			S_CU: begin
				mctl = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, hi: 1'b0};
				ma   = acc[31:0];
				mb   = 32'(smag);
			end
			S_A0: begin
				mctl = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, hi: 1'b0};
				ma   = n32;
				mb   = s2_q[31:0];
			end
			S_A1: begin
				mctl = '{valid: 1'b1, clr: 1'b0, sub: 1'b0, hi: 1'b1};
				ma   = n32;
				mb   = 32'(s2_q[47:32]);
			end
			S_B0: begin
				mctl = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, hi: 1'b0};
				ma   = m1;
				mb   = m1;
			end
			S_D: begin
				mctl = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, hi: 1'b0};
				ma   = n32;
				mb   = n32;
			end
			S_K0: begin
				mctl = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, hi: 1'b0};
				ma   = n3;
				mb   = s2_q[31:0];
			end
			S_K1: begin
				mctl = '{valid: 1'b1, clr: 1'b0, sub: 1'b0, hi: 1'b1};
				ma   = n3;
				mb   = 32'(s2_q[47:32]);
			end
			// third-moment numerator n^2*S3 - 3n*S1*S2 + 2*S1^3, mod 2^128
			S_N0: begin
				mctl = '{valid: 1'b1, clr: 1'b1, sub: s3_q[63], hi: 1'b0};
				ma   = nn_q;
				mb   = s3m[31:0];
			end
			S_N1: begin
				mctl = '{valid: 1'b1, clr: 1'b0, sub: s3_q[63], hi: 1'b1};
				ma   = nn_q;
				mb   = s3m[63:32];
			end
			S_N2: begin
				mctl = '{valid: 1'b1, clr: 1'b0, sub: ~neg1, hi: 1'b0};
				ma   = k_q[31:0];
				mb   = m1;
			end
			S_N3: begin
				mctl = '{valid: 1'b1, clr: 1'b0, sub: ~neg1, hi: 1'b1};
				ma   = k_q[63:32];
				mb   = m1;
			end
			S_N4: begin
				mctl = '{valid: 1'b1, clr: 1'b0, sub: neg1, hi: 1'b0};
				ma   = j64[31:0];
				mb   = m1;
			end
			S_N5: begin
				mctl = '{valid: 1'b1, clr: 1'b0, sub: neg1, hi: 1'b1};
				ma   = j64[63:32];
				mb   = m1;
			end
			S_R0: begin
				mctl = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, hi: 1'b0};
				ma   = d_q[31:0];
				mb   = r_q;
			end
			S_R1: begin
				mctl = '{valid: 1'b1, clr: 1'b0, sub: 1'b0, hi: 1'b1};
				ma   = d_q[63:32];
				mb   = r_q;
			end
			default: begin
				mctl = '0;
			end
		endcase
	end

	// divide / square-root requests
	always_comb begin
		dreq = '{start: 1'b0, op: DU_DIV};
		dnum = '0;
		dden = '0;
		case (state_q)
			S_K0: begin
				dreq = '{start: 1'b1, op: DU_SQRT};
				dnum = {64'd0, d_q};
			end
			S_SKG: begin
				dreq = '{start: 1'b1, op: DU_DIV};
				dnum = num_q;
				dden = acc;
			end
			S_MG: begin
				dreq = '{start: 1'b1, op: DU_DIV};
				dnum = {95'd0, m1, 1'b0} + 128'(n_q);
				dden = 128'({n_q, 1'b0});
			end
			S_SG: begin
				dreq = '{start: 1'b1, op: DU_DIV};
				dnum = {96'd0, r_q};
				dden = 128'(n_q);
			end
			default: begin
				dreq = '{start: 1'b0, op: DU_DIV};
			end
		endcase
	end

	// result selection
	always_comb begin
		if (pend_q[0]) begin
			pick      = 3'b001;
			pick_kind = KIND_MEAN;
			pick_val  = neg1 ? 32'd0 - mean_q : mean_q;
		end else if (pend_q[1]) begin
			pick      = 3'b010;
			pick_kind = KIND_STDDEV;
			pick_val  = std_q;
		end else begin
			pick      = 3'b100;
			pick_kind = KIND_SKEWNESS;
			pick_val  = (d_q == 64'd0) ? 32'd0 : skew_q;
		end
		rest = pend_q & ~pick;
		load = (state_q == S_EMIT) && (pend_q != 3'b000) && (!stat_valid_q || stat_ready);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SQ) begin
			rd_q <= mem_q[addr_q];
		end
		if (mem_we) begin
			mem_q[addr_q] <= mem_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			en_mean_q    <= 1'b1;
			en_std_q     <= 1'b1;
			en_skew_q    <= 1'b0;
			clr_tick_q   <= 1'b0;
			valid_q      <= '0;
			tick_q       <= '0;
			pend_q       <= '0;
			stat_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ENABLE_MEAN:     en_mean_q  <= cfg_data[0];
					REG_ENABLE_STDDEV:   en_std_q   <= cfg_data[0];
					REG_ENABLE_SKEWNESS: en_skew_q  <= cfg_data[0];
					REG_CLEAR_PER_TICK:  clr_tick_q <= cfg_data[0];
					default: ;
				endcase
			end

			if (stat_valid_q && stat_ready) begin
				stat_valid_q <= 1'b0;
			end
			if (load) begin
				stat_valid_q         <= 1'b1;
				stat_q.out_channel   <= item_q.channel;
				stat_q.kind          <= pick_kind;
				stat_q.value         <= signed'(pick_val);
				stat_q.last          <= (rest == 3'b000);
				stat_q.overflow      <= (n_q == LIMIT);
				pend_q               <= rest;
			end

			case (state_q)
				S_IDLE: begin
					if (sample_valid && ({29'd0, sample_item.channel} < 32'(CHANNELS))) begin
						item_q  <= sample_item;
						addr_q  <= ch_ext[AW-1:0];
						state_q <= S_SQ;
					end
				end
				S_SQ:  state_q <= S_SQW;
				S_SQW: state_q <= S_CU;
				S_CU: begin
					smag2_q <= acc[30:0];
					state_q <= S_CUW;
				end
				S_CUW: state_q <= S_UPD;
				S_UPD: begin
					valid_q[addr_q] <= 1'b1;
					tick_q[addr_q]  <= item_q.report;
					s1_q <= s1n;
					s2_q <= s2n;
					s3_q <= s3n;
					n_q  <= nn_new;
					state_q <= item_q.report ? S_A0 : S_IDLE;
				end
				S_A0: state_q <= S_A1;
				S_A1: state_q <= S_AW;
				S_AW: state_q <= S_B0;
				S_B0: begin
					a_q     <= acc[63:0];
					state_q <= S_BW;
				end
				S_BW: state_q <= S_D;
				S_D: begin
					// n^2-scaled variance, clamped at zero
					sq_q    <= sq_acc;
					d_q     <= (a_q >= sq_acc) ? a_q - sq_acc : 64'd0;
					state_q <= S_DW;
				end
				S_DW: state_q <= S_K0;
				S_K0: begin
					nn_q    <= acc[31:0];
					state_q <= S_K1;
				end
				S_K1: state_q <= S_KW;
				S_KW: state_q <= S_N0;
				S_N0: begin
					k_q     <= acc[63:0];
					state_q <= S_N1;
				end
				S_N1: state_q <= S_N2;
				S_N2: state_q <= S_N3;
				S_N3: state_q <= S_N4;
				S_N4: state_q <= S_N5;
				S_N5: state_q <= S_NW;
				S_NW: state_q <= S_E0;
				S_E0: begin
					skneg_q <= acc[127];
					num_q   <= {nmag[112:0], 15'd0};
					state_q <= S_RT;
				end
				S_RT: begin
					if (!du_busy) begin
						r_q     <= quo[31:0];
						state_q <= S_R0;
					end
				end
				S_R0:  state_q <= S_R1;
				S_R1:  state_q <= S_RW;
				S_RW:  state_q <= S_SKG;
				S_SKG: state_q <= S_SKW;
				S_SKW: begin
					if (!du_busy) begin
						skew_q  <= skew_sat;
						state_q <= S_MG;
					end
				end
				S_MG: state_q <= S_MW;
				S_MW: begin
					if (!du_busy) begin
						mean_q  <= quo[31:0];
						state_q <= S_SG;
					end
				end
				S_SG: state_q <= S_SW;
				S_SW: begin
					if (!du_busy) begin
						std_q   <= quo[31:0];
						pend_q  <= {en_skew_q, en_std_q, en_mean_q};
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (pend_q == 3'b000 || (load && rest == 3'b000)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample_ready = (state_q == S_IDLE);
	assign stat_valid   = stat_valid_q;
	assign stat_item    = stat_q;

endmodule

// File: test/running_mean_stddev_skewness_top_tb.sv
// ----------------------------------------------------------------------------
// running_mean_stddev_skewness_top_tb
// Feeds Q1.15 samples on eight channels and checks each mean, stddev and
// skewness report against an exact integer model of the per-channel running
// sums, under several register settings and idle patterns on the input and output sides.
// ----------------------------------------------------------------------------
module running_mean_stddev_skewness_top_tb;
	import rmss_pkg::*;

	localparam int NCH       = 8;
	localparam int CNT_LIMIT = (1 << 16) - 1;
	localparam int RAND_ITEMS = 445;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [0:0]   cfg_data;
	logic         sample_valid;
	logic         sample_ready;
	sample_item_t sample_item;
	logic         stat_valid;
	logic         stat_ready;
	stat_item_t   stat_item;

	running_mean_stddev_skewness_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_item  (sample_item),
		.stat_valid   (stat_valid),
		.stat_ready   (stat_ready),
		.stat_item    (stat_item)
	);

	// model state
	longint      ch_s1 [NCH];
	logic [63:0] ch_s2 [NCH];
	longint      ch_s3 [NCH];
	int          ch_n  [NCH];
	bit          ch_tick [NCH];
	bit          en_mean, en_sd, en_skew, clr_tick;

	stat_item_t  pending_stats[$];
	int          mismatches;
	int          send_idle_pct;
	int          recv_stall_pct;

	typedef struct {
		bit           is_cfg;
		logic [1:0]   idx;
		bit           val;
		sample_item_t it;
		bit           typed;
		int           exp_mean;
		int           exp_sd;
	} stim_row_t;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("running_mean_stddev_skewness_top_tb: FAIL");
		$finish;
	end

	function automatic logic [63:0] floor_sqrt(logic [63:0] x);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 64'd0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x = x - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic [31:0] skew_of(logic [63:0] n, logic [63:0] m1, bit neg1,
			logic [63:0] s2, longint s3, logic [63:0] d);
		logic [127:0] t1, t2, t3, acc, den, q;
		logic [63:0]  k;
		bit           neg;
		if (d == 0 || n == 0) return 32'd0;
		k = (s3 < 0) ? 64'(-s3) : 64'(s3);
		t1 = 128'(n * n) * 128'(k);
		if (s3 < 0) t1 = -t1;
		k = n * s2;
		k = k * 64'd3;
		t2 = 128'(k) * 128'(m1);
		k = m1 * m1;
		k = k << 1;
		t3 = 128'(k) * 128'(m1);
		if (neg1) begin
			t2 = -t2;
			t3 = -t3;
		end
		acc = t1 - t2 + t3;
		neg = acc[127];
		if (neg) acc = -acc;
		acc = acc << 15;
		den = 128'(d) * 128'(floor_sqrt(d));
		q = acc / den;
		if (neg) begin
			if (q > 128'h8000_0000) return 32'h8000_0000;
			return -q[31:0];
		end
		if (q > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
		return q[31:0];
	endfunction

	// updates the channel sums and queues the statistics the item reports
	function automatic void accumulate_sample(sample_item_t it);
		int          c;
		longint      s;
		logic [63:0] n, m1, d, a, sq, r;
		bit          neg1, ovf;
		stat_item_t  res[$];
		stat_item_t  one;
		c = int'(it.channel);
		s = longint'(it.sample);
		if (it.restart || (clr_tick && ch_tick[c])) begin
			ch_s1[c] = 0;
			ch_s2[c] = 0;
			ch_s3[c] = 0;
			ch_n[c] = 0;
		end
		ch_tick[c] = it.report;
		if (ch_n[c] < CNT_LIMIT) begin
			ch_s1[c] += s;
			ch_s2[c] += 64'(s * s);
			ch_s3[c] += s * s * s;
			ch_n[c]++;
		end
		if (!it.report) return;
		n = 64'(ch_n[c]);
		ovf = ch_n[c] >= CNT_LIMIT;
		neg1 = ch_s1[c] < 0;
		m1 = neg1 ? 64'(-ch_s1[c]) : 64'(ch_s1[c]);
		a = n * ch_s2[c];
		sq = m1 * m1;
		d = (a >= sq) ? a - sq : 64'd0;
		one.out_channel = it.channel;
		one.last = 1'b0;
		one.overflow = ovf;
		if (en_mean) begin
			r = (n != 0) ? (64'd2 * m1 + n) / (64'd2 * n) : 64'd0;
			one.kind = KIND_MEAN;
			one.value = neg1 ? -r[31:0] : r[31:0];
			res.push_back(one);
		end
		if (en_sd) begin
			r = (n != 0) ? floor_sqrt(d) / n : 64'd0;
			one.kind = KIND_STDDEV;
			one.value = r[31:0];
			res.push_back(one);
		end
		if (en_skew) begin
			one.kind = KIND_SKEWNESS;
			one.value = skew_of(n, m1, neg1, ch_s2[c], ch_s3[c], d);
			res.push_back(one);
		end
		if (res.size() > 0) res[res.size() - 1].last = 1'b1;
		foreach (res[i]) pending_stats.push_back(res[i]);
	endfunction

	task automatic send_sample(sample_item_t it);
		int gap;
		if ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			gap = $urandom_range(6, 1);
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_item <= it;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		accumulate_sample(it);
	endtask

	// waits for every result and for the block to settle before a register write
	task automatic write_reg(logic [1:0] idx, bit val);
		sample_valid <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ENABLE_MEAN:     en_mean = val;
			REG_ENABLE_STDDEV:   en_sd = val;
			REG_ENABLE_SKEWNESS: en_skew = val;
			REG_CLEAR_PER_TICK:  clr_tick = val;
			default: ;
		endcase
	endtask

	function automatic sample_item_t make_item(int c, int s, bit rs, bit rp);
		sample_item_t it;
		it.channel = 3'(c);
		it.sample = 16'(s);
		it.restart = rs;
		it.report = rp;
		return it;
	endfunction

	function automatic stim_row_t srow(int c, int s, bit rs, bit rp);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.it = make_item(c, s, rs, rp);
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic stim_row_t crow(logic [1:0] idx, bit v);
		stim_row_t r;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = v;
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic stim_row_t trow(int c, int s, int m, int sd);
		stim_row_t r;
		r = srow(c, s, 1'b0, 1'b1);
		r.typed = 1'b1;
		r.exp_mean = m;
		r.exp_sd = sd;
		return r;
	endfunction

	function automatic int rand_sample();
		case ($urandom_range(5))
			0: return 32767;
			1: return -32768;
			2: return $urandom_range(40) - 20;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_ready <= 1'b0;
		end else begin
			stat_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && stat_valid && stat_ready) begin
			if (pending_stats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected statistic: %p", stat_item);
			end else begin
				if (stat_item !== pending_stats[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", pending_stats[0], stat_item);
				end
				void'(pending_stats.pop_front());
			end
		end
	end

	initial begin
		stim_row_t    rows[$];
		sample_item_t it;
		int           qpos;
		int           wait_cycles;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_valid = 1'b0;
		sample_item = '0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int c = 0; c < NCH; c++) begin
			ch_s1[c] = 0;
			ch_s2[c] = 0;
			ch_s3[c] = 0;
			ch_n[c] = 0;
			ch_tick[c] = 1'b0;
		end
		en_mean = 1'b1;
		en_sd = 1'b1;
		en_skew = 1'b0;
		clr_tick = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single samples after reset: mean is the sample, no spread
		rows.push_back(trow(0, 32767, 32767, 0));
		rows.push_back(trow(1, -32768, -32768, 0));
		rows.push_back(trow(2, 0, 0, 0));
		rows.push_back(srow(0, -32768, 1'b0, 1'b1));
		rows.push_back(srow(1, 32767, 1'b1, 1'b1));
		rows.push_back(crow(REG_ENABLE_SKEWNESS, 1'b1));
		rows.push_back(srow(3, 1000, 1'b0, 1'b0));
		rows.push_back(srow(3, 1000, 1'b0, 1'b1)); // constant channel, skewness zero
		rows.push_back(srow(4, -32768, 1'b0, 1'b0));
		rows.push_back(srow(4, 32767, 1'b0, 1'b0));
		rows.push_back(srow(4, 32767, 1'b0, 1'b1));
		rows.push_back(srow(5, 32767, 1'b0, 1'b0));
		rows.push_back(srow(5, -32768, 1'b0, 1'b0));
		rows.push_back(srow(5, -32768, 1'b0, 1'b1));
		rows.push_back(srow(6, 5, 1'b0, 1'b0));
		rows.push_back(srow(6, -7, 1'b1, 1'b1));
		rows.push_back(crow(REG_CLEAR_PER_TICK, 1'b1));
		rows.push_back(srow(4, 12345, 1'b0, 1'b1)); // cleared after the last report
		rows.push_back(srow(4, -300, 1'b0, 1'b1));
		rows.push_back(crow(REG_ENABLE_MEAN, 1'b0));
		rows.push_back(crow(REG_ENABLE_STDDEV, 1'b0));
		rows.push_back(crow(REG_ENABLE_SKEWNESS, 1'b0));
		rows.push_back(srow(7, 100, 1'b0, 1'b1)); // nothing enabled, no results
		rows.push_back(srow(7, 200, 1'b0, 1'b0));
		rows.push_back(crow(REG_ENABLE_MEAN, 1'b1));
		rows.push_back(crow(REG_ENABLE_STDDEV, 1'b1));
		rows.push_back(crow(REG_ENABLE_SKEWNESS, 1'b1));
		rows.push_back(crow(REG_CLEAR_PER_TICK, 1'b0));
		rows.push_back(srow(7, 300, 1'b0, 1'b1));

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				write_reg(rows[i].idx, rows[i].val);
			end else begin
				send_sample(rows[i].it);
				// typed rows report mean and stddev, the last two queued entries
				if (rows[i].typed) begin
					qpos = pending_stats.size() - 2;
					pending_stats[qpos].value = rows[i].exp_mean;
					pending_stats[qpos + 1].value = rows[i].exp_sd;
				end
			end
		end

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 95 == 0) begin
				case ((i / 95) % 5)
					0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
					1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
					2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
					3: begin send_idle_pct = 28; recv_stall_pct = 28; end
					default: begin send_idle_pct = 0; recv_stall_pct = 0; end
				endcase
				if (i != 0) begin
					write_reg(REG_ENABLE_MEAN, 1'($urandom_range(1)));
					write_reg(REG_ENABLE_STDDEV, 1'($urandom_range(1)));
					write_reg(REG_ENABLE_SKEWNESS, 1'($urandom_range(1)));
					write_reg(REG_CLEAR_PER_TICK, 1'($urandom_range(1)));
				end
			end
			it = make_item($urandom_range(7), rand_sample(),
				$urandom_range(19) == 0, $urandom_range(3) == 0);
			send_sample(it);
		end
		sample_valid <= 1'b0;

		wait_cycles = 0;
		while (pending_stats.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (600) @(posedge clk);
		if (mismatches == 0 && pending_stats.size() == 0) begin
			$display("running_mean_stddev_skewness_top_tb: PASS");
		end else begin
			$display("running_mean_stddev_skewness_top_tb: FAIL");
		end
		$finish;
	end

endmodule
